FILE: hdl/ils_pkg.sv
// ils_pkg: shared constants, operation and status codes and transaction
// structs for the indexed list store. No dependencies.
`timescale 1ns / 1ps

package ils_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // fixed widths of the transaction fields
   localparam int OP_W       = 3;
   localparam int POS_W      = 5;
   localparam int WORD_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int MATCH_W    = 5;
   localparam int FILL_W     = 5;

   localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
   localparam logic [OP_W-1:0] OP_DROP      = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ      = 3'd4;
   localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd5;
   localparam logic [OP_W-1:0] OP_FIND      = 3'd6;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  position;
      logic [WORD_W-1:0] word;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   read_word;
      logic [MATCH_W-1:0]  match_index;
      logic [FILL_W-1:0]   fill_count;
      logic                list_empty;
   } result_type;

endpackage

FILE: hdl/ils_engine.sv
// ils_engine: element memory, fill count and the sequencer that walks the
// memory for shifts and searches. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_engine
   import ils_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  request_type req,
   output logic        res_valid,
   input  logic        res_ready,
   output result_type  res
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_FIND  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]      last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic                  up_ff, up_in;
   logic                  issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [WORD_W-1:0]     rword_ff, rword_in;
   logic [MATCH_W-1:0]    match_ff, match_in;

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rdata_ff;
   logic                  we;
   logic [IDX_W-1:0]      waddr;
   logic [WORD_WIDTH-1:0] wdata;
   logic [IDX_W-1:0]      raddr;

   logic                  full;
   logic                  pos_gt_cnt;
   logic                  pos_ge_cnt;
   logic [IDX_W-1:0]      cnt_m1;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign pos_gt_cnt = (32'(req.position) > 32'(count_ff));
   assign pos_ge_cnt = (32'(req.position) >= 32'(count_ff));
   assign cnt_m1     = IDX_W'(count_ff - 1'b1);

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res.status      = status_ff;
      res.read_word   = rword_ff;
      res.match_index = match_ff;
      res.fill_count  = FILL_W'(count_ff);
      res.list_empty  = (count_ff == '0);
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      last_idx_in = last_idx_ff;
      wr_idx_in   = wr_idx_ff;
      pos_in      = pos_ff;
      up_in       = up_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      word_in     = word_ff;
      status_in   = status_ff;
      rword_in    = rword_ff;
      match_in    = match_ff;
      we          = 1'b0;
      waddr       = wr_idx_ff;
      wdata       = rdata_ff;
      raddr       = rd_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            raddr = req.position[IDX_W-1:0];
            if (req_valid) begin
               word_in   = WORD_WIDTH'(req.word);
               pos_in    = req.position[IDX_W-1:0];
               status_in = ST_OK;
               rword_in  = '0;
               match_in  = '0;
               state_in  = S_DONE;
               issue_in  = 1'b1;
               pend_in   = 1'b0;
               unique case (req.op)
                  OP_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        we       = 1'b1;
                        waddr    = count_ff[IDX_W-1:0];
                        wdata    = WORD_WIDTH'(req.word);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DROP: begin
                     if (count_ff == '0) begin
                        status_in = ST_RANGE;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (pos_gt_cnt) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        if (32'(req.position) == 32'(count_ff)) begin
                           we    = 1'b1;
                           waddr = req.position[IDX_W-1:0];
                           wdata = WORD_WIDTH'(req.word);
                        end else begin
                           // walk from the tail down, moving each entry up one
                           up_in       = 1'b1;
                           rd_idx_in   = cnt_m1;
                           last_idx_in = req.position[IDX_W-1:0];
                           state_in    = S_SHIFT;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_ge_cnt) begin
                        status_in = ST_RANGE;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (req.position[IDX_W-1:0] != cnt_m1) begin
                           up_in       = 1'b0;
                           rd_idx_in   = IDX_W'(req.position[IDX_W-1:0] + 1'b1);
                           last_idx_in = cnt_m1;
                           state_in    = S_SHIFT;
                        end
                     end
                  end
                  OP_READ: begin
                     if (pos_ge_cnt) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_OVERWRITE: begin
                     if (pos_ge_cnt) begin
                        status_in = ST_RANGE;
                     end else begin
                        we    = 1'b1;
                        waddr = req.position[IDX_W-1:0];
                        wdata = WORD_WIDTH'(req.word);
                     end
                  end
                  OP_FIND: begin
                     if (count_ff != '0) begin
                        rd_idx_in   = '0;
                        last_idx_in = cnt_m1;
                        state_in    = S_FIND;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            rword_in = WORD_W'(rdata_ff);
            state_in = S_DONE;
         end
         S_SHIFT: begin
            // read one entry per cycle, write it to its new place in the next cycle
            if (pend_ff) begin
               we    = 1'b1;
               waddr = wr_idx_ff;
               wdata = rdata_ff;
            end
            if (issue_ff) begin
               pend_in   = 1'b1;
               wr_idx_in = up_ff ? IDX_W'(rd_idx_ff + 1'b1) : IDX_W'(rd_idx_ff - 1'b1);
               if (rd_idx_ff == last_idx_ff) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = up_ff ? IDX_W'(rd_idx_ff - 1'b1) : IDX_W'(rd_idx_ff + 1'b1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // pipeline drained; an insert still places its new word
                  if (up_ff) begin
                     we    = 1'b1;
                     waddr = pos_ff;
                     wdata = word_ff;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_FIND: begin
            if (issue_ff) begin
               pend_in   = 1'b1;
               wr_idx_in = rd_idx_ff;
               if (rd_idx_ff == last_idx_ff) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = IDX_W'(rd_idx_ff + 1'b1);
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (rdata_ff == word_ff)) begin
               match_in = MATCH_W'(wr_idx_ff);
               state_in = S_DONE;
            end else if (!issue_ff && !pend_ff) begin
               match_in = MATCH_W'(count_ff);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      wr_idx_ff   <= wr_idx_in;
      pos_ff      <= pos_in;
      up_ff       <= up_in;
      issue_ff    <= issue_in;
      pend_ff     <= pend_in;
      word_ff     <= word_in;
      status_ff   <= status_in;
      rword_ff    <= rword_in;
      match_ff    <= match_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

FILE: hdl/indexed_list_store_top.sv
// indexed_list_store_top: stream ports, result register and checks around
// the list engine. Depends on ils_pkg and ils_engine.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser op, tdata position and word
//   rsp      out  rsp_tvalid/rsp_tready  tuser status, tdata result fields
//
// one transaction at a time; append, drop, overwrite, clear, a rejected
// request and a tail insert or remove finish without a memory walk, a read
// waits for the memory read, remove and insert walk the entries between the
// position and the tail, find walks up to count entries; the single memory read port walks one entry a cycle.
// reset clears the fill count but not the element memory.
// a stalled result sits in the output register while the next one is built.
`timescale 1ns / 1ps

module indexed_list_store_top
   import ils_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // op
   input  logic [39:0] req_tdata,   // position, word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [47:0] rsp_tdata    // read_word, match_index, fill_count, list_empty
);

   request_type req;
   result_type  eng_res;
   logic        eng_valid;
   logic        eng_ready;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   always_comb begin
      req.op       = req_tuser[OP_W-1:0];
      req.position = req_tdata[POS_W-1:0];
      req.word     = req_tdata[POS_W+WORD_W-1:POS_W];
   end

   ils_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res       (eng_res)
   );

   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_ready) begin
         rsp_valid_in = eng_valid;
         if (eng_valid) begin
            rsp_data_in = eng_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {5'd0, rsp_data_ff.list_empty, rsp_data_ff.fill_count,
                        rsp_data_ff.match_index, rsp_data_ff.read_word};

`ifndef NO_ASSERTIONS
   // a full status only comes back with a full store
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_data_ff.status == ST_FULL))
         |-> (32'(rsp_data_ff.fill_count) == DEPTH))
      else $error("full status with store not full");

   // a found index never lies beyond the fill count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data_ff.match_index <= rsp_data_ff.fill_count))
      else $error("match index beyond fill count");

   // the engine holds one request at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while engine busy");

   // a rejected request reads back no data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_data_ff.status != ST_OK)) |-> (rsp_data_ff.read_word == '0))
      else $error("read data on a rejected request");
`endif

endmodule

FILE: dv/indexed_list_store_top_tb.sv
// indexed_list_store_top_tb: self-checking bench for the indexed list store, with an
// in-bench list predictor, random idling on both streams and a long result hold-off.
// Depends on ils_pkg and indexed_list_store_top.
`timescale 1ns / 1ps

module indexed_list_store_top_tb;
   import ils_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int GAP_MAX      = 7;
   localparam int STALL_MAX    = 7;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE       = 40;
   localparam int RANDOM_ITEMS = 1850;
   localparam int PHASES       = 8;
   localparam int REPORT_MAX   = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = '0;   // op
   logic [39:0] req_tdata  = '0;   // position, word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;         // status
   logic [47:0] rsp_tdata;         // read_word, match_index, fill_count, list_empty

   indexed_list_store_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // predicted list contents and fill count
   logic [WORD_W-1:0] list_words [DEPTH];
   int                list_count = 0;
   result_type        pending_results [$];

   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;
   int hold_request    = 0;

   int mismatches      = 0;
   int strays          = 0;
   int reported        = 0;
   int checked_results = 0;
   int idle_cycles     = 0;
   int op_tally [8]    = '{default: 0};
   int full_rejects    = 0;
   int range_rejects   = 0;
   int peak_fill       = 0;

   // applies one request to the predicted list, returns the result it yields
   function automatic result_type apply_request(input logic [OP_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic [WORD_W-1:0] w);
      result_type r;
      int         p;
      int         i;
      bit         found;
      r = '0;
      p = int'(pos);
      found = 1'b0;
      case (op)
         OP_APPEND: begin
            if (list_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_words[list_count] = w;
               list_count++;
            end
         end
         OP_DROP: begin
            if (list_count == 0) r.status = ST_RANGE;
            else list_count--;
         end
         OP_INSERT: begin
            if (p > list_count) begin
               r.status = ST_RANGE;
            end else if (list_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_count; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = w;
               list_count++;
            end
         end
         OP_REMOVE: begin
            if (p >= list_count) begin
               r.status = ST_RANGE;
            end else begin
               for (i = p; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         OP_READ: begin
            if (p >= list_count) r.status = ST_RANGE;
            else r.read_word = list_words[p];
         end
         OP_OVERWRITE: begin
            if (p >= list_count) r.status = ST_RANGE;
            else list_words[p] = w;
         end
         OP_FIND: begin
            r.match_index = MATCH_W'(list_count);
            for (i = 0; i < list_count; i++) begin
               if (!found && list_words[i] == w) begin
                  r.match_index = MATCH_W'(i);
                  found = 1'b1;
               end
            end
         end
         default: begin
            list_count = 0;
         end
      endcase
      r.fill_count = FILL_W'(list_count);
      r.list_empty = (list_count == 0);
      return r;
   endfunction

   // offers one request, waits for its transaction, then records the prediction
   task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] w);
      int         gap;
      result_type r;
      gap = sender_gaps ? int'($urandom_range(0, GAP_MAX)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, w, pos};
      do @(posedge clock); while (!req_tready);
      r = apply_request(op, pos, w);
      pending_results.insert(pending_results.size(), r);
      op_tally[op]++;
      if (r.status == ST_FULL) full_rejects++;
      if (r.status == ST_RANGE) range_rejects++;
      if (list_count > peak_fill) peak_fill = list_count;
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word(input bit for_find);
      int sel;
      if (for_find && list_count > 0 && $urandom_range(0, 9) < 6)
         return list_words[$urandom_range(0, list_count - 1)];
      sel = $urandom_range(0, 9);
      if (sel < 4) return $urandom;
      else if (sel < 6) return $urandom_range(0, 3);   // small values give duplicates
      else if (sel < 7) return '0;
      else if (sel < 8) return '1;
      else return 32'h1 << $urandom_range(0, 31);
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input bit grow);
      int r;
      r = $urandom_range(0, 99);
      if (r < (grow ? 25 : 8)) return OP_APPEND;
      else if (r < (grow ? 45 : 15)) return OP_INSERT;
      else if (r < (grow ? 53 : 40)) return OP_REMOVE;
      else if (r < (grow ? 58 : 55)) return OP_DROP;
      else if (r < (grow ? 73 : 70)) return OP_READ;
      else if (r < (grow ? 83 : 80)) return OP_OVERWRITE;
      else if (r < (grow ? 98 : 95)) return OP_FIND;
      else return OP_CLEAR;
   endfunction

   task automatic random_request(input bit grow);
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] w;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any op, any position
         op  = OP_W'($urandom_range(0, 7));
         pos = POS_W'($urandom_range(0, DEPTH));
         w   = pick_word(1'b0);
      end else begin
         op = pick_op(grow);
         if (op == OP_INSERT)
            pos = POS_W'($urandom_range(0, list_count));
         else if ((op == OP_REMOVE || op == OP_READ || op == OP_OVERWRITE) && list_count > 0)
            pos = POS_W'($urandom_range(0, list_count - 1));
         else
            pos = POS_W'($urandom_range(0, DEPTH));
         w = pick_word(op == OP_FIND);
      end
      send_request(op, pos, w);
   endtask

   task automatic test_empty_store;
      send_request(OP_DROP, 5'd0, 32'h0);
      send_request(OP_REMOVE, 5'd0, 32'hFFFF_FFFF);
      send_request(OP_READ, 5'd0, 32'h0);
      send_request(OP_OVERWRITE, 5'd16, 32'h1234_5678);
      send_request(OP_FIND, 5'd0, 32'h0);
      send_request(OP_INSERT, 5'd1, 32'hDEAD_BEEF);
      send_request(OP_CLEAR, 5'd16, 32'hFFFF_FFFF);
   endtask

   task automatic test_basic_ops;
      send_request(OP_INSERT, 5'd0, 32'h0000_0000);
      send_request(OP_APPEND, 5'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 5'd2, 32'hA5A5_A5A5);      // at the end
      send_request(OP_INSERT, 5'd1, 32'h5A5A_5A5A);      // shifts two entries up
      send_request(OP_READ, 5'd1, 32'h0);
      send_request(OP_READ, 5'd3, 32'h0);
      send_request(OP_FIND, 5'd0, 32'hFFFF_FFFF);
      send_request(OP_FIND, 5'd0, 32'h1234_5678);        // no match
      send_request(OP_APPEND, 5'd0, 32'h0000_0000);      // duplicate of entry 0
      send_request(OP_FIND, 5'd0, 32'h0000_0000);        // first of two matches
      send_request(OP_OVERWRITE, 5'd4, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 5'd0, 32'h0);
      send_request(OP_READ, 5'd4, 32'h0);                // position equal to count
      send_request(OP_REMOVE, 5'd4, 32'h0);
      send_request(OP_INSERT, 5'd5, 32'h0F0F_0F0F);      // past the end
      send_request(OP_INSERT, 5'd4, 32'hF0F0_F0F0);
      send_request(OP_DROP, 5'd0, 32'h0);
      send_request(OP_CLEAR, 5'd0, 32'h0);
      send_request(OP_READ, 5'd0, 32'h0);
   endtask

   // results are held off while the store is filled, so the input backs up
   task automatic test_full_store;
      int i;
      sender_gaps  = 1'b0;
      hold_request = HOLD_CYCLES;
      for (i = 0; i < DEPTH; i++) begin
         if (i % 3 == 1)
            send_request(OP_INSERT, POS_W'($urandom_range(0, list_count)), pick_word(1'b0));
         else send_request(OP_APPEND, 5'd16, pick_word(1'b0));
      end
      send_request(OP_APPEND, 5'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 5'd16, 32'h1);
      send_request(OP_INSERT, 5'd0, 32'h2);
      send_request(OP_READ, 5'd15, 32'h0);
      send_request(OP_READ, 5'd16, 32'h0);
      send_request(OP_FIND, 5'd0, list_words[DEPTH-1]);
      send_request(OP_REMOVE, 5'd15, 32'h0);
      send_request(OP_INSERT, 5'd15, 32'hCAFE_0001);
      send_request(OP_REMOVE, 5'd0, 32'h0);              // longest shift down
      send_request(OP_INSERT, 5'd0, 32'hCAFE_0002);      // longest shift up
      send_request(OP_OVERWRITE, 5'd15, 32'h8000_0000);
      sender_gaps = 1'b1;
   endtask

   task automatic test_random;
      int phase;
      int n;
      for (phase = 0; phase < PHASES; phase++) begin
         sender_gaps     = (phase % 4 == 0) || (phase % 4 == 2);
         receiver_stalls = (phase % 4 == 0) || (phase % 4 == 3);
         for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
            random_request((phase + phase / 4) % 2 == 0);
      end
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // result sink: random stall before each transaction, or a requested long hold
   initial begin : result_sink
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = receiver_stalls ? int'($urandom_range(0, STALL_MAX)) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tuser;
         got.read_word   = rsp_tdata[31:0];
         got.match_index = rsp_tdata[36:32];
         got.fill_count  = rsp_tdata[41:37];
         got.list_empty  = rsp_tdata[42];
         checked_results++;
         if (pending_results.size() == 0) begin
            strays++;
            reported++;
            if (reported <= REPORT_MAX)
               $display("unexpected result: status %0d read %h match %0d fill %0d empty %b",
                        got.status, got.read_word, got.match_index, got.fill_count,
                        got.list_empty);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               reported++;
               if (reported <= REPORT_MAX) begin
                  $display("mismatch on result %0d: expected status %0d read %h match %0d",
                           checked_results, want.status, want.read_word, want.match_index);
                  $display("   expected fill %0d empty %b", want.fill_count,
                           want.list_empty);
                  $display("   actual status %0d read %h match %0d fill %0d empty %b",
                           got.status, got.read_word, got.match_index, got.fill_count,
                           got.list_empty);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles with no transaction", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_store;
      drain_results;
      test_basic_ops;
      drain_results;
      test_full_store;
      drain_results;
      test_random;
      drain_results;
      $display("ran %0d requests, append to clear: %0d %0d %0d %0d %0d %0d %0d %0d",
               op_tally.sum(), op_tally[OP_APPEND], op_tally[OP_DROP], op_tally[OP_INSERT],
               op_tally[OP_REMOVE], op_tally[OP_READ], op_tally[OP_OVERWRITE],
               op_tally[OP_FIND], op_tally[OP_CLEAR]);
      $display("full rejections %0d, range rejections %0d, peak fill %0d, %0d results checked",
               full_rejects, range_rejects, peak_fill, checked_results);
      if (mismatches == 0 && strays == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing", mismatches, strays,
                  pending_results.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
